// ===== design/nba_pkg.sv =====
// ----------------------------------------------------------------------------
// nba_pkg
// Shared types and constants of the NACK bitmask aggregator.
// ----------------------------------------------------------------------------
package nba_pkg;

  localparam int SEQ_W   = 16;
  localparam int MASK_W  = 16;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 3;
  localparam int SPAN    = 16;

  typedef enum logic [STAT_W-1:0] {
    ST_MERGED = 3'd0,
    ST_NEW    = 3'd1,
    ST_FULL   = 3'd2,
    ST_PAIR   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

endpackage

// ===== design/nack_bitmask_aggregator_core.sv =====
// ----------------------------------------------------------------------------
// nack_bitmask_aggregator_core
// Collects lost sequence numbers into base/bitmask pairs and emits them on
// flush, tagged with the flow id.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): an add carries a lost sequence number,
// a flush asks for every held pair. Result channel (out_valid/out_stall):
// one result per add, one per held entry on flush (last marks the final
// one), or a single empty status on flush of an empty table.
// cfg_wr_en/cfg_wr_data load the flow id; write it only while idle.
// One item is taken at a time; in_stall is high from acceptance until its
// last result transfers. Stored entries sit in one RAM with registered read,
// scanned one entry at a time by a single compare/shift unit: each entry is
// read (S_RD), then checked (S_CHK); a flush also presents each entry as a
// result (S_OUT) before the next is read. An add on an empty table, or a
// flush of one, goes straight to S_OUT. A result stays in S_OUT while the
// receiver holds out_stall high; a stalled result holds.
// Reset empties the table (no clearing pass) and zeroes the flow id.
// ----------------------------------------------------------------------------
module nack_bitmask_aggregator_core
  import nba_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SEQ_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [SEQ_W-1:0]  in_seq_num,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [SEQ_W-1:0]  out_seq_base,
  output logic [MASK_W-1:0] out_bit_mask,
  output logic [IDX_W-1:0]  out_entry_index,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [SEQ_W-1:0]  out_flow_tag,
  output logic              out_last
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = SEQ_W + MASK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             req_r, req_nxt;
  logic [SEQ_W-1:0] sn_r, sn_nxt;
  logic [SEQ_W-1:0] flow_id_r, flow_id_nxt;

  status_t          status_r, status_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [IDX_W-1:0] eidx_r, eidx_nxt;
  logic [CNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [SEQ_W-1:0] tag_r, tag_nxt;
  logic             last_r, last_nxt;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;

  logic [SEQ_W-1:0]  rd_base;
  logic [MASK_W-1:0] rd_mask;
  logic [SEQ_W:0]    diff;
  logic              hit;
  logic [4:0]        off;
  logic [MASK_W-1:0] set_bit;
  logic [MASK_W-1:0] merged_mask;
  logic [CW-1:0]     idx_inc;
  logic              more;
  logic              xfer_out;

  nba_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_base     = ram_rdata[RW-1:MASK_W];
  assign rd_mask     = ram_rdata[MASK_W-1:0];
  assign diff        = {1'b0, sn_r} - {1'b0, rd_base};
  assign hit         = !diff[SEQ_W] && (diff[SEQ_W-1:0] <= SEQ_W'(SPAN));
  assign off         = diff[4:0];
  assign set_bit     = MASK_W'(1) << (5'(SPAN) - off);
  assign merged_mask = (off != 5'd0) ? (rd_mask | set_bit) : rd_mask;
  assign idx_inc     = CW'(idx_r) + CW'(1);
  assign more        = idx_inc < count_r;
  assign xfer_out    = (state_r == S_OUT) && !out_stall;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_seq_base    = base_r;
  assign out_bit_mask    = mask_r;
  assign out_entry_index = eidx_r;
  assign out_entry_count = ecnt_r;
  assign out_flow_tag    = tag_r;
  assign out_last        = last_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    req_nxt     = req_r;
    sn_nxt      = sn_r;
    flow_id_nxt = cfg_wr_en ? cfg_wr_data : flow_id_r;
    status_nxt  = status_r;
    base_nxt    = base_r;
    mask_nxt    = mask_r;
    eidx_nxt    = eidx_r;
    ecnt_nxt    = ecnt_r;
    tag_nxt     = tag_r;
    last_nxt    = last_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {rd_base, merged_mask};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;
          sn_nxt  = in_seq_num;
          idx_nxt = '0;
          tag_nxt = '0;
          last_nxt = 1'b1;
          if (count_r != '0) begin
            state_nxt = S_RD;
          end else if (in_req_type == REQ_FLUSH) begin
            status_nxt = ST_EMPTY;
            base_nxt   = '0;
            mask_nxt   = '0;
            eidx_nxt   = '0;
            ecnt_nxt   = '0;
            state_nxt  = S_OUT;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = {in_seq_num, {MASK_W{1'b0}}};
            count_nxt  = CW'(1);
            status_nxt = ST_NEW;
            base_nxt   = in_seq_num;
            mask_nxt   = '0;
            eidx_nxt   = '0;
            ecnt_nxt   = CNT_W'(1);
            state_nxt  = S_OUT;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (req_r == REQ_FLUSH) begin
          status_nxt = ST_PAIR;
          base_nxt   = rd_base;
          mask_nxt   = rd_mask;
          eidx_nxt   = IDX_W'(idx_r);
          ecnt_nxt   = CNT_W'(count_r);
          tag_nxt    = flow_id_r;
          last_nxt   = !more;
          state_nxt  = S_OUT;
        end else if (hit) begin
          ram_we     = (off != 5'd0);
          status_nxt = ST_MERGED;
          base_nxt   = rd_base;
          mask_nxt   = merged_mask;
          eidx_nxt   = IDX_W'(idx_r);
          ecnt_nxt   = CNT_W'(count_r);
          state_nxt  = S_OUT;
        end else if (more) begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_RD;
        end else if (count_r >= CW'(MAX_ENTRIES)) begin
          status_nxt = ST_FULL;
          base_nxt   = sn_r;
          mask_nxt   = '0;
          eidx_nxt   = '0;
          ecnt_nxt   = CNT_W'(count_r);
          state_nxt  = S_OUT;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = count_r[IW-1:0];
          ram_wdata  = {sn_r, {MASK_W{1'b0}}};
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_NEW;
          base_nxt   = sn_r;
          mask_nxt   = '0;
          eidx_nxt   = IDX_W'(count_r);
          ecnt_nxt   = CNT_W'(count_r + CW'(1));
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (xfer_out) begin
          if (req_r == REQ_FLUSH && !last_r) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_RD;
          end else begin
            if (req_r == REQ_FLUSH) begin
              count_nxt = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      flow_id_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      flow_id_r <= flow_id_nxt;
    end
    idx_r    <= idx_nxt;
    req_r    <= req_nxt;
    sn_r     <= sn_nxt;
    status_r <= status_nxt;
    base_r   <= base_nxt;
    mask_r   <= mask_nxt;
    eidx_r   <= eidx_nxt;
    ecnt_r   <= ecnt_nxt;
    tag_r    <= tag_nxt;
    last_r   <= last_nxt;
  end

endmodule

// ===== design/nba_ram.sv =====
// ----------------------------------------------------------------------------
// nba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
